// ===== hw/rtl/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types and constants for the parallel port adapter.
// ----------------------------------------------------------------------------
package ppa_pkg;

  localparam int unsigned InWidth  = 40;
  localparam int unsigned OutWidth = 40;

  localparam logic [5:0] CtrlMask = 6'h3f;
  localparam int unsigned SelDataBit = 2;
  localparam int unsigned EdgeRiseBit = 1;
  localparam int unsigned IrqEnBit = 0;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RISE  = 2'd2,
    CMD_FALL  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_DATA_A = 2'd0,
    SEL_CTRL_A = 2'd1,
    SEL_DATA_B = 2'd2,
    SEL_CTRL_B = 2'd3
  } sel_t;

  // one request to a side, decoded by the top level
  typedef struct packed {
    logic       wr_data;
    logic       wr_ctrl;
    logic       rd_data;
    logic       edge_ev;
    logic       rising;
    logic [7:0] wdata;
  } side_req_t;

  typedef struct packed {
    logic [5:0] ctrl;
    logic [7:0] dir;
    logic [7:0] outreg;
    logic       flag;
    logic       irq;
  } side_state_t;

  function automatic logic [7:0] sink_level(input side_state_t s);
    return s.outreg | ~s.dir;
  endfunction

  function automatic logic [7:0] source_level(input side_state_t s);
    return s.outreg & s.dir;
  endfunction

endpackage

// ===== hw/rtl/ppa_side.sv =====
// ----------------------------------------------------------------------------
// ppa_side
// Register set of one port side: control, direction, output, flag and irq.
// ----------------------------------------------------------------------------
module ppa_side
  import ppa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  side_req_t   req,
  output side_state_t state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (en) begin
      if (req.wr_data) begin
        if (state.ctrl[SelDataBit]) begin
          state.outreg <= req.wdata;
        end else begin
          state.dir <= req.wdata;
        end
      end
      if (req.wr_ctrl) begin
        state.ctrl <= req.wdata[5:0] & CtrlMask;
        state.irq  <= req.wdata[IrqEnBit] & (state.irq | state.flag);
      end
      if (req.rd_data && state.ctrl[SelDataBit]) begin
        state.flag <= 1'b0;
        state.irq  <= 1'b0;
      end
      if (req.edge_ev && (state.ctrl[EdgeRiseBit] == req.rising)) begin
        state.flag <= 1'b1;
        state.irq  <= state.ctrl[IrqEnBit];
      end
    end
  end

endmodule

// ===== hw/rtl/parallel_port_adapter.sv =====
// ----------------------------------------------------------------------------
// parallel_port_adapter
// Two-side parallel interface adapter: bus accesses and CX1 edge events in,
// one result with read data, pin levels and irq lines out per request.
//
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | command, reg_select, write_data,
//         |     |                        | edge_side, pin levels
// m_axis  | out | m_axis_tvalid/tready   | read_data, pin levels, irq_a/irq_b
//
// One request per cycle sustained while m_axis_tready is high; a request passes the
// input register, then side registers and result register are updated together.
// rst is synchronous and clears all side registers and both valid flags.
// A stalled output holds the input register; s_axis_tready drops only when
// both stages are full.
// ----------------------------------------------------------------------------
module parallel_port_adapter
  import ppa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] command, [3:2] reg_select, [11:4] write_data, [12] edge_side,
  // [20:13] port_a_pins_in, [28:21] port_b_pins_pull_low,
  // [36:29] port_b_pins_drive_high, [39:37] zero
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] read_data, [15:8] port_a_drive_level, [23:16] port_b_source_level,
  // [31:24] port_b_drive_level, [32] irq_a, [33] irq_b, [39:34] zero
  output logic [OutWidth-1:0] m_axis_tdata
);

  logic               in_valid;
  logic [InWidth-1:0] in_data;
  logic               advance;
  logic               step;

  cmd_t        cmd;
  sel_t        sel;
  logic [7:0]  wd;
  logic        es;
  logic [7:0]  a_in;
  logic [7:0]  b_low;
  logic [7:0]  b_high;
  logic        is_bus;
  logic        to_b;
  side_req_t   req_a;
  side_req_t   req_b;
  side_state_t st_a;
  side_state_t st_b;
  logic [7:0]  rd;
  logic [7:0]  src_b;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
  end

  assign cmd    = cmd_t'(in_data[1:0]);
  assign sel    = sel_t'(in_data[3:2]);
  assign wd     = in_data[11:4];
  assign es     = in_data[12];
  assign a_in   = in_data[20:13];
  assign b_low  = in_data[28:21];
  assign b_high = in_data[36:29];

  assign is_bus = (cmd == CMD_READ) || (cmd == CMD_WRITE);
  assign to_b   = is_bus ? sel[1] : es;

  always_comb begin
    side_req_t r;
    r.wr_data = (cmd == CMD_WRITE) && !sel[0];
    r.wr_ctrl = (cmd == CMD_WRITE) && sel[0];
    r.rd_data = (cmd == CMD_READ) && !sel[0];
    r.edge_ev = !is_bus;
    r.rising  = (cmd == CMD_RISE);
    r.wdata   = wd;
    req_a = to_b ? side_req_t'('0) : r;
    req_b = to_b ? r : side_req_t'('0);
  end

  ppa_side u_side_a (
    .clk   (clk),
    .rst   (rst),
    .en    (step),
    .req   (req_a),
    .state (st_a)
  );

  ppa_side u_side_b (
    .clk   (clk),
    .rst   (rst),
    .en    (step),
    .req   (req_b),
    .state (st_b)
  );

  assign src_b = source_level(st_b);

  always_comb begin
    rd = '0;
    if (cmd == CMD_READ) begin
      case (sel)
        SEL_DATA_A: begin
          rd = st_a.ctrl[SelDataBit] ? (sink_level(st_a) & a_in) : st_a.dir;
        end
        SEL_CTRL_A: rd = {st_a.flag, 1'b0, st_a.ctrl};
        SEL_DATA_B: begin
          rd = st_b.ctrl[SelDataBit]
             ? (src_b | ((src_b | b_high) & sink_level(st_b) & b_low & ~st_b.dir))
             : st_b.dir;
        end
        SEL_CTRL_B: rd = {st_b.flag, 1'b0, st_b.ctrl};
        default:    rd = '0;
      endcase
    end
  end

  // result levels reflect the side registers after this request
  side_state_t st_a_next;
  side_state_t st_b_next;

  function automatic side_state_t side_next(input side_state_t s, input side_req_t q);
    side_state_t n;
    n = s;
    if (q.wr_data) begin
      if (s.ctrl[SelDataBit]) begin
        n.outreg = q.wdata;
      end else begin
        n.dir = q.wdata;
      end
    end
    if (q.wr_ctrl) begin
      n.ctrl = q.wdata[5:0] & CtrlMask;
      n.irq  = q.wdata[IrqEnBit] & (s.irq | s.flag);
    end
    if (q.rd_data && s.ctrl[SelDataBit]) begin
      n.flag = 1'b0;
      n.irq  = 1'b0;
    end
    if (q.edge_ev && (s.ctrl[EdgeRiseBit] == q.rising)) begin
      n.flag = 1'b1;
      n.irq  = s.ctrl[IrqEnBit];
    end
    return n;
  endfunction

  assign st_a_next = side_next(st_a, req_a);
  assign st_b_next = side_next(st_b, req_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
    if (step) begin
      m_axis_tdata <= {6'd0, st_b_next.irq, st_a_next.irq,
                       sink_level(st_b_next), source_level(st_b_next),
                       sink_level(st_a_next), rd};
    end
  end

endmodule
